// ===== hw/rtl/qpd_pkg.sv =====
// Package: shared types, constants and hex digit decode for the quoted-printable decoder.
package qpd_pkg;

    localparam logic [7:0] EQ_CHAR  = 8'h3D;
    localparam logic [7:0] CR_CHAR  = 8'h0D;
    localparam logic [7:0] LF_CHAR  = 8'h0A;
    localparam int unsigned HEX_BASE = 16;

    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_EQ      = 2'd1,
        PEND_EQ_BYTE = 2'd2
    } t_pend;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       out_last;
    } t_result;

    typedef struct packed {
        logic [1:0]                  n;
        t_result [MAX_RESULTS-1:0]   items;
        t_pend                       next_state;
        logic [7:0]                  next_held;
    } t_decode;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h41 + 8'd10);
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/qpd_in_if.sv =====
// Interface: input byte channel with valid/ready handshake.
interface qpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/qpd_out_if.sv =====
// Interface: decoded result channel with valid/ready handshake.
interface qpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_last;

    modport source (output valid, output out_byte, output byte_present, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_present, input out_last,
                    output ready);
endinterface

// ===== hw/rtl/qpd_decode.sv =====
// Decode step: resolves one input byte against the held escape into up to three results.
module qpd_decode (
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  qpd_pkg::t_pend  i_state,
    input  logic [7:0]      i_held,
    output qpd_pkg::t_decode o_dec
);

    qpd_pkg::t_hex hex_hi;
    qpd_pkg::t_hex hex_lo;
    logic [1:0]    n;
    logic [1:0]    n_prev;

    assign hex_hi = qpd_pkg::hex_value(i_held);
    assign hex_lo = qpd_pkg::hex_value(i_byte);

    always_comb begin
        o_dec            = '0;
        o_dec.next_state = i_state;
        o_dec.next_held  = i_held;
        n                = 2'd0;
        n_prev           = 2'd0;

        case (i_state)
            qpd_pkg::PEND_NONE: begin
                if (i_byte == qpd_pkg::EQ_CHAR && !i_last) begin
                    o_dec.next_state = qpd_pkg::PEND_EQ;
                end else begin
                    o_dec.items[n] = '{i_byte, 1'b1, 1'b0};
                    n = n + 2'd1;
                end
            end
            qpd_pkg::PEND_EQ: begin
                if (i_last) begin
                    o_dec.next_state = qpd_pkg::PEND_NONE;
                    o_dec.items[n] = '{qpd_pkg::EQ_CHAR, 1'b1, 1'b0};
                    n = n + 2'd1;
                    o_dec.items[n] = '{i_byte, 1'b1, 1'b0};
                    n = n + 2'd1;
                end else begin
                    o_dec.next_held  = i_byte;
                    o_dec.next_state = qpd_pkg::PEND_EQ_BYTE;
                end
            end
            default: begin
                o_dec.next_state = qpd_pkg::PEND_NONE;
                if (i_held == qpd_pkg::CR_CHAR && i_byte == qpd_pkg::LF_CHAR) begin
                    n = 2'd0;
                end else if (i_held == qpd_pkg::LF_CHAR) begin
                    if (i_byte == qpd_pkg::EQ_CHAR && !i_last) begin
                        o_dec.next_state = qpd_pkg::PEND_EQ;
                    end else begin
                        o_dec.items[n] = '{i_byte, 1'b1, 1'b0};
                        n = n + 2'd1;
                    end
                end else if (hex_hi.valid && hex_lo.valid) begin
                    o_dec.items[n] = '{{hex_hi.value, hex_lo.value}, 1'b1, 1'b0};
                    n = n + 2'd1;
                end else begin
                    o_dec.items[n] = '{qpd_pkg::EQ_CHAR, 1'b1, 1'b0};
                    n = n + 2'd1;
                    if (i_held == qpd_pkg::EQ_CHAR) begin
                        if (i_last) begin
                            o_dec.items[n] = '{qpd_pkg::EQ_CHAR, 1'b1, 1'b0};
                            n = n + 2'd1;
                            o_dec.items[n] = '{i_byte, 1'b1, 1'b0};
                            n = n + 2'd1;
                        end else begin
                            o_dec.next_held  = i_byte;
                            o_dec.next_state = qpd_pkg::PEND_EQ_BYTE;
                        end
                    end else begin
                        o_dec.items[n] = '{i_held, 1'b1, 1'b0};
                        n = n + 2'd1;
                        if (i_byte == qpd_pkg::EQ_CHAR && !i_last) begin
                            o_dec.next_state = qpd_pkg::PEND_EQ;
                        end else begin
                            o_dec.items[n] = '{i_byte, 1'b1, 1'b0};
                            n = n + 2'd1;
                        end
                    end
                end
            end
        endcase

        if (i_last) begin
            o_dec.next_state = qpd_pkg::PEND_NONE;
            if (n == 2'd0) begin
                o_dec.items[0] = '{8'h00, 1'b0, 1'b1};
                n = 2'd1;
            end else begin
                n_prev = n - 2'd1;
                o_dec.items[n_prev].out_last = 1'b1;
            end
        end
        o_dec.n = n;
    end

endmodule

// ===== hw/rtl/quoted_printable_decoder_unit.sv =====
// Top level: quoted-printable decoder with pending-escape state and a result queue.
// Results enter a registered shift queue of QUEUE_DEPTH entries, read from its head.
// Throughput: one input beat per cycle while input ready is high; each beat yields
// zero to three results, drained one per cycle while the output is ready.
// Input ready drops while fewer than three queue entries are free.
// Reset empties the queue and clears the held escape.
module quoted_printable_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = qpd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    qpd_in_if.sink             i_in,
    qpd_out_if.source          o_out
);

    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IDX = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    qpd_pkg::t_pend   r_state;
    qpd_pkg::t_pend   n_state;
    logic [7:0]       r_held;
    logic [7:0]       n_held;
    qpd_pkg::t_result r_q [QUEUE_DEPTH];
    qpd_pkg::t_result n_q [QUEUE_DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    qpd_pkg::t_decode dec;
    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    logic [CW-1:0]    base;
    logic [CW-1:0]    pos;

    qpd_decode u_decode (
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .i_state (r_state),
        .i_held  (r_held),
        .o_dec   (dec)
    );

    assign i_in.ready         = (r_count <= CW'(QUEUE_DEPTH - qpd_pkg::MAX_RESULTS));
    assign accept             = i_in.valid && i_in.ready;
    assign o_out.valid        = (r_count != '0);
    assign o_out.out_byte     = r_q[0].out_byte;
    assign o_out.byte_present = r_q[0].byte_present;
    assign o_out.out_last     = r_q[0].out_last;
    assign pop                = o_out.valid && o_out.ready;
    assign push_n             = accept ? dec.n : 2'd0;
    assign base               = r_count - CW'(pop);

    always_comb begin
        n_state = accept ? dec.next_state : r_state;
        n_held  = accept ? dec.next_held : r_held;
        n_count = base + CW'(push_n);
        pos     = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int j = 0; j < qpd_pkg::MAX_RESULTS; j++) begin
            if (2'(j) < push_n) begin
                pos = base + CW'(j);
                n_q[pos[IDX-1:0]] = dec.items[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpd_pkg::PEND_NONE;
            r_held  <= 8'h00;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_count <= n_count;
        end
        r_q <= n_q;
    end

endmodule
